[src/chkt_pkg.sv]
// ----------------------------------------------------------------------------
// chkt_pkg
// Shared types and constants for the coalesced hash key table.
// ----------------------------------------------------------------------------
package chkt_pkg;

  localparam int unsigned KeyW  = 32;
  localparam int unsigned SlotW = 8;

  localparam logic [KeyW-1:0] EmptyKey = '1;

  localparam logic ReqLookup = 1'b0;
  localparam logic ReqDrop   = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FIND,
    ST_INS_HOME,
    ST_FREE_ISSUE,
    ST_FREE_CHK,
    ST_LINK_F,
    ST_LINK_H,
    ST_UNLINK,
    ST_PLACE,
    ST_MOVE_RD,
    ST_MOVE_LINK,
    ST_RESP
  } chkt_state_e;

endpackage

[src/coalesced_hash_key_table.sv]
// ----------------------------------------------------------------------------
// coalesced_hash_key_table
// Coalesced-chained hash table of 32-bit keys with a lookup-or-insert and a
// drop request, one result per request.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass, one table row per cycle, and
// stalls its input until the pass is done. Each request then runs under a
// small sequencer around a table memory with one write port and one read
// port whose data is registered, so every chain step, free-slot probe and
// row update is a separate sequencer step. A live hit walks the chain from
// the home row; a plain insert adds a home-row read; an insert that must
// find a free slot adds a probe for each slot tried by the downward free
// pointer, and an insert that evicts a guest adds a walk of the guest's
// chain plus up to four row updates. The input is taken only while the
// sequencer is idle; a finished result waits in the output register, so
// the next request can be taken while it is still pending.
// The all-ones key is reserved and returns an all-zero result.
// ----------------------------------------------------------------------------
module coalesced_hash_key_table #(
  parameter int unsigned TABLE_SIZE = 256
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       req_type_i,
  input  logic [chkt_pkg::KeyW-1:0]  key_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [chkt_pkg::SlotW-1:0] slot_o,
  output logic                       existed_o,
  output logic                       created_o,
  output logic                       full_res_o
);
  import chkt_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_SIZE);

  // One table row: key, live flag and the chain link with its own valid bit.
  typedef struct packed {
    logic [KeyW-1:0] key;
    logic            live;
    logic            lnk_v;
    logic [AW-1:0]   lnk;
  } row_t;

  localparam logic [AW-1:0] LastIdx = AW'(TABLE_SIZE - 1);

  row_t mem [TABLE_SIZE];
  row_t rd_q;

  logic          we, rd_en;
  logic [AW-1:0] waddr, raddr;
  row_t          wdata;

  chkt_state_e   state_q, state_d;
  logic          req_q, req_d;
  logic [KeyW-1:0] key_q, key_d;
  logic [AW-1:0] cur_q, cur_d, cnt_q, cnt_d, f_q, f_d;
  logic [AW:0]   fp_q, fp_d;
  logic [KeyW-1:0] g_q, g_d;
  logic          glive_q, glive_d, guest_q, guest_d;
  logic          hlink_v_q, hlink_v_d;
  logic [AW-1:0] hlink_q, hlink_d;
  logic [AW-1:0] res_slot_q, res_slot_d;
  logic          res_ex_q, res_ex_d, res_cr_q, res_cr_d, res_full_q, res_full_d;
  logic          out_valid_q, out_valid_d;
  logic [SlotW-1:0] slot_q, slot_d;
  logic          existed_q, existed_d, created_q, created_d, full_q, full_d;

  logic [AW-1:0] home;
  logic          fp_done;

  assign home    = key_q[AW-1:0];
  assign fp_done = fp_q[AW];

  // Table memory with registered read; a same-cycle write is forwarded.
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rd_q <= (we && (waddr == raddr)) ? wdata : mem[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      cnt_q       <= '0;
      fp_q        <= {1'b0, LastIdx};
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      fp_q        <= fp_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    key_q      <= key_d;
    cur_q      <= cur_d;
    f_q        <= f_d;
    g_q        <= g_d;
    glive_q    <= glive_d;
    guest_q    <= guest_d;
    hlink_v_q  <= hlink_v_d;
    hlink_q    <= hlink_d;
    res_slot_q <= res_slot_d;
    res_ex_q   <= res_ex_d;
    res_cr_q   <= res_cr_d;
    res_full_q <= res_full_d;
    slot_q     <= slot_d;
    existed_q  <= existed_d;
    created_q  <= created_d;
    full_q     <= full_d;
  end

  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    key_d       = key_q;
    cur_d       = cur_q;
    cnt_d       = cnt_q;
    f_d         = f_q;
    fp_d        = fp_q;
    g_d         = g_q;
    glive_d     = glive_q;
    guest_d     = guest_q;
    hlink_v_d   = hlink_v_q;
    hlink_d     = hlink_q;
    res_slot_d  = res_slot_q;
    res_ex_d    = res_ex_q;
    res_cr_d    = res_cr_q;
    res_full_d  = res_full_q;
    slot_d      = slot_q;
    existed_d   = existed_q;
    created_d   = created_q;
    full_d      = full_q;
    out_valid_d = out_valid_q && out_stall_i;
    in_stall_o  = 1'b1;
    we          = 1'b0;
    waddr       = cur_q;
    wdata       = rd_q;
    rd_en       = 1'b0;
    raddr       = cur_q;

    unique case (state_q)
      ST_CLEAR: begin
        we    = 1'b1;
        waddr = cnt_q;
        wdata = '{key: EmptyKey, live: 1'b0, lnk_v: 1'b0, lnk: '0};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == LastIdx) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          req_d      = req_type_i;
          key_d      = key_i;
          res_slot_d = '0;
          res_ex_d   = 1'b0;
          res_cr_d   = 1'b0;
          res_full_d = 1'b0;
          if (key_i == EmptyKey) begin
            state_d = ST_RESP;
          end else begin
            cur_d   = key_i[AW-1:0];
            cnt_d   = '0;
            rd_en   = 1'b1;
            raddr   = key_i[AW-1:0];
            state_d = ST_FIND;
          end
        end
      end

      // Chain walk from the home slot.
      ST_FIND: begin
        if (rd_q.key == key_q) begin
          res_slot_d = cur_q;
          state_d    = ST_RESP;
          if (req_q == ReqDrop) begin
            res_ex_d   = rd_q.live;
            we         = 1'b1;
            wdata.live = 1'b0;
          end else if (rd_q.live) begin
            res_ex_d = 1'b1;
          end else begin
            res_cr_d   = 1'b1;
            we         = 1'b1;
            wdata.live = 1'b1;
          end
        end else if (!rd_q.lnk_v || cnt_q == LastIdx) begin
          if (req_q == ReqDrop) begin
            state_d = ST_RESP;
          end else begin
            rd_en   = 1'b1;
            raddr   = home;
            cur_d   = home;
            state_d = ST_INS_HOME;
          end
        end else begin
          cur_d   = rd_q.lnk;
          cnt_d   = cnt_q + 1'b1;
          rd_en   = 1'b1;
          raddr   = rd_q.lnk;
        end
      end

      ST_INS_HOME: begin
        g_d       = rd_q.key;
        glive_d   = rd_q.live;
        hlink_v_d = rd_q.lnk_v;
        hlink_d   = rd_q.lnk;
        guest_d   = (rd_q.key[AW-1:0] != home);
        if (rd_q.key == EmptyKey) begin
          we         = 1'b1;
          waddr      = home;
          wdata.key  = key_q;
          wdata.live = 1'b1;
          res_slot_d = home;
          res_cr_d   = 1'b1;
          state_d    = ST_RESP;
        end else if (rd_q.key[AW-1:0] != home && !rd_q.live) begin
          // A dropped guest is discarded without taking a free slot.
          cur_d   = rd_q.key[AW-1:0];
          cnt_d   = '0;
          rd_en   = 1'b1;
          raddr   = rd_q.key[AW-1:0];
          state_d = ST_UNLINK;
        end else begin
          state_d = ST_FREE_ISSUE;
        end
      end

      ST_FREE_ISSUE: begin
        if (fp_done) begin
          res_full_d = 1'b1;
          state_d    = ST_RESP;
        end else begin
          rd_en   = 1'b1;
          raddr   = fp_q[AW-1:0];
          f_d     = fp_q[AW-1:0];
          fp_d    = fp_q - 1'b1;
          state_d = ST_FREE_CHK;
        end
      end

      ST_FREE_CHK: begin
        if (rd_q.key == EmptyKey) begin
          if (guest_q) begin
            cur_d   = g_q[AW-1:0];
            cnt_d   = '0;
            rd_en   = 1'b1;
            raddr   = g_q[AW-1:0];
            state_d = ST_UNLINK;
          end else begin
            state_d = ST_LINK_F;
          end
        end else if (fp_done) begin
          res_full_d = 1'b1;
          state_d    = ST_RESP;
        end else begin
          rd_en = 1'b1;
          raddr = fp_q[AW-1:0];
          f_d   = fp_q[AW-1:0];
          fp_d  = fp_q - 1'b1;
        end
      end

      // New key goes into the free slot, linked right after its home.
      ST_LINK_F: begin
        we      = 1'b1;
        waddr   = f_q;
        wdata   = '{key: key_q, live: 1'b1, lnk_v: hlink_v_q, lnk: hlink_q};
        state_d = ST_LINK_H;
      end

      ST_LINK_H: begin
        we         = 1'b1;
        waddr      = home;
        wdata      = '{key: g_q, live: glive_q, lnk_v: 1'b1, lnk: f_q};
        res_slot_d = f_q;
        res_cr_d   = 1'b1;
        state_d    = ST_RESP;
      end

      // Walk the guest's chain to cut the home slot out of it.
      ST_UNLINK: begin
        if (rd_q.lnk_v && rd_q.lnk == home) begin
          we          = 1'b1;
          waddr       = cur_q;
          wdata.lnk_v = hlink_v_q;
          wdata.lnk   = hlink_q;
          state_d     = ST_PLACE;
        end else if (!rd_q.lnk_v || cnt_q == LastIdx) begin
          state_d = ST_PLACE;
        end else begin
          cur_d = rd_q.lnk;
          cnt_d = cnt_q + 1'b1;
          rd_en = 1'b1;
          raddr = rd_q.lnk;
        end
      end

      ST_PLACE: begin
        we    = 1'b1;
        waddr = home;
        wdata = '{key: key_q, live: 1'b1, lnk_v: 1'b0, lnk: '0};
        res_slot_d = home;
        res_cr_d   = 1'b1;
        if (glive_q) begin
          rd_en   = 1'b1;
          raddr   = g_q[AW-1:0];
          state_d = ST_MOVE_RD;
        end else begin
          state_d = ST_RESP;
        end
      end

      // Live guest moves to the free slot right after its own home.
      ST_MOVE_RD: begin
        we      = 1'b1;
        waddr   = f_q;
        wdata   = '{key: g_q, live: 1'b1, lnk_v: rd_q.lnk_v, lnk: rd_q.lnk};
        state_d = ST_MOVE_LINK;
      end

      ST_MOVE_LINK: begin
        we          = 1'b1;
        waddr       = g_q[AW-1:0];
        wdata.lnk_v = 1'b1;
        wdata.lnk   = f_q;
        state_d     = ST_RESP;
      end

      ST_RESP: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          slot_d      = SlotW'(res_slot_q);
          existed_d   = res_ex_q;
          created_d   = res_cr_q;
          full_d      = res_full_q;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign slot_o      = slot_q;
  assign existed_o   = existed_q;
  assign created_o   = created_q;
  assign full_res_o  = full_q;

endmodule
